/* rtl/core/fccm_pkg.sv */
// Shared types, codes and constants of the FAT cluster chain manager.
package fccm_pkg;

  // Field widths of the request and result items.
  localparam int ENTRY_W   = 32;
  localparam int CLUSTER_W = 12;
  localparam int LINK_W    = 28;
  localparam int TOP_W     = ENTRY_W - LINK_W;
  localparam int USE_W     = 13;

  // Default table depth.
  localparam int FAT_ENTRIES_DEF = 4096;

  // End-of-chain marks and the first data cluster.
  localparam logic [LINK_W-1:0] EOC32      = 28'hFFFFFF8;
  localparam logic [LINK_W-1:0] EOC16      = 28'h000FFF8;
  localparam int                FIRST_DATA = 2;

  // Reset values of the configuration registers.
  localparam logic             FAT_IS_32_RST      = 1'b1;
  localparam logic [USE_W-1:0] ENTRIES_IN_USE_RST = 13'd4096;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_ALLOC = 2'd2,
    REQ_FREE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    CFG_FAT_IS_32      = 1'b0,
    CFG_ENTRIES_IN_USE = 1'b1
  } cfg_idx_t;

  // Decoded view of one table entry.
  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic              eoc;
    logic              free;
    logic              match;
  } link_info_t;

  // Build an entry word that holds a new link, keeping the top bits in 32-bit mode.
  function automatic logic [ENTRY_W-1:0] mk_entry(input logic             is32,
                                                  input logic [TOP_W-1:0]  top,
                                                  input logic [LINK_W-1:0] link);
    logic [ENTRY_W-1:0] w;
    if (is32) begin
      w = {top, link};
    end else begin
      w = {16'd0, link[15:0]};
    end
    return w;
  endfunction

endpackage

/* rtl/core/fccm_table.sv */
// Table memory: one write port and one read port with registered read data.
module fccm_table #(
  parameter int DEPTH = fccm_pkg::FAT_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [fccm_pkg::ENTRY_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic [fccm_pkg::ENTRY_W-1:0] rdata
);
  import fccm_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data: the data is valid in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/fccm_link_unit.sv */
// Shared link decoder: extracts the link of an entry and compares it.
module fccm_link_unit (
  input  logic                         is32,
  input  logic [fccm_pkg::ENTRY_W-1:0] raw,
  input  logic [fccm_pkg::LINK_W-1:0]  target,
  output fccm_pkg::link_info_t         info
);
  import fccm_pkg::*;

  logic [LINK_W-1:0] link;

  // Link field depends on the entry format.
  assign link = is32 ? raw[LINK_W-1:0] : {{(LINK_W-16){1'b0}}, raw[15:0]};

  // End of chain, free entry and match against the searched cluster.
  always_comb begin
    info.link  = link;
    info.eoc   = is32 ? (link >= EOC32) : (link >= EOC16);
    info.free  = (link == '0);
    info.match = (link == target);
  end

endmodule

/* rtl/core/fat_cluster_chain_manager_top.sv */
// Top level of the FAT cluster chain manager: sequencer, configuration and result register.
// The block holds the allocation table in a single-port-read memory and serves one item
// at a time. A load goes from dispatch to the result step, and a read passes the named
// cluster's read in between. Allocate and free-tail read the named cluster and then scan
// the table one entry per cycle through the memory read port; the entries scanned are at
// most the active limit, up to FAT_ENTRIES.
// The input is not ready while an item is in progress; a finished result waits in the
// output register; the next item is accepted, but its result waits until that one is taken.
module fat_cluster_chain_manager_top #(
  parameter int FAT_ENTRIES = fccm_pkg::FAT_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fccm_pkg::req_t                 req_type,
  input  logic [fccm_pkg::CLUSTER_W-1:0] cluster,
  input  logic [fccm_pkg::ENTRY_W-1:0]   entry_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fccm_pkg::LINK_W-1:0]    cluster_out,
  output fccm_pkg::status_t              status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  fccm_pkg::cfg_idx_t             cfg_index,
  input  logic [fccm_pkg::ENTRY_W-1:0]   cfg_data
);
  import fccm_pkg::*;

  localparam int AW  = $clog2(FAT_ENTRIES);
  localparam int LW0 = $clog2(FAT_ENTRIES + 1);
  localparam int LW  = (LW0 > USE_W) ? LW0 : USE_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(FAT_ENTRIES);
  localparam logic [LW-1:0] FIRST_L = LW'(FIRST_DATA);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CLRD,
    S_SCAN,
    S_WR_HIT,
    S_WR_CL,
    S_RESP
  } state_t;

  state_t             state;
  logic               fat_is_32;
  logic [USE_W-1:0]   entries_in_use;
  req_t               req_q;
  logic [LW-1:0]      cl_q;
  logic [ENTRY_W-1:0] val_q;
  logic [LW-1:0]      lim_q;
  logic [LW-1:0]      ptr;
  logic               issued_last;
  logic               rd_pend;
  logic               rd_last;
  logic [LW-1:0]      rd_idx;
  logic [LW-1:0]      hit_idx;
  logic [TOP_W-1:0]   hit_top;
  logic [TOP_W-1:0]   cl_top;
  logic [LINK_W-1:0]  res_cl;
  status_t            res_st;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  link_info_t         lk;
  logic [LW-1:0]      use_ext;
  logic [LW-1:0]      lim;
  logic [LW-1:0]      alloc_start;
  logic               is_last;
  logic [LW-1:0]      ptr_next;
  logic               hit;
  logic               is_alloc;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign is_alloc  = (req_q == REQ_ALLOC);

  // Active limit is the smaller of the register and the table depth.
  assign use_ext = LW'(entries_in_use);
  assign lim     = (use_ext < DEPTH_L) ? use_ext : DEPTH_L;

  // Scan bounds and pointer step.
  assign alloc_start = (cl_q < FIRST_L) ? FIRST_L : cl_q + LW'(1);
  assign is_last     = is_alloc ? (ptr + LW'(1) == lim_q) : (ptr == FIRST_L);
  assign ptr_next    = is_alloc ? ptr + LW'(1) : ptr - LW'(1);
  assign hit         = rd_pend && (is_alloc ? lk.free : lk.match);

  fccm_table #(
    .DEPTH (FAT_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fccm_link_unit u_link (
    .is32   (fat_is_32),
    .raw    (mem_rdata),
    .target (LINK_W'(cl_q)),
    .info   (lk)
  );

  // Memory port selection by sequencer state.
  always_comb begin
    mem_raddr = (state == S_SCAN) ? ptr[AW-1:0] : cl_q[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = cl_q[AW-1:0];
    mem_wdata = val_q;
    unique case (state)
      S_DISPATCH: begin
        mem_we = (req_q == REQ_LOAD) && (cl_q < DEPTH_L);
      end
      S_WR_HIT: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx[AW-1:0];
        mem_wdata = mk_entry(fat_is_32, hit_top, fat_is_32 ? EOC32 : EOC16);
      end
      S_WR_CL: begin
        mem_we    = 1'b1;
        mem_wdata = mk_entry(fat_is_32, cl_top, is_alloc ? LINK_W'(hit_idx) : '0);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fat_is_32      <= FAT_IS_32_RST;
      entries_in_use <= ENTRIES_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FAT_IS_32:      fat_is_32      <= cfg_data[0];
        CFG_ENTRIES_IN_USE: entries_in_use <= cfg_data[USE_W-1:0];
        default:            fat_is_32      <= fat_is_32;
      endcase
    end
  end

  // Sequencer, scan bookkeeping and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      issued_last <= 1'b0;
    end else begin
      // The result step refills the output register itself.
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q <= req_type;
            cl_q  <= LW'(cluster);
            val_q <= entry_value;
            lim_q <= lim;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_cl <= '0;
          unique case (req_q)
            REQ_LOAD: begin
              res_st <= (cl_q >= DEPTH_L) ? ST_RANGE : ST_OK;
              state  <= S_RESP;
            end
            REQ_READ: begin
              if (cl_q >= DEPTH_L) begin
                res_st <= ST_RANGE;
                state  <= S_RESP;
              end else begin
                res_st <= ST_OK;
                state  <= S_CLRD;
              end
            end
            REQ_ALLOC: begin
              if (cl_q >= lim_q) begin
                res_st <= ST_RANGE;
                state  <= S_RESP;
              end else if (alloc_start >= lim_q) begin
                res_st <= ST_NONE;
                state  <= S_RESP;
              end else begin
                res_st <= ST_OK;
                ptr    <= alloc_start;
                state  <= S_CLRD;
              end
            end
            REQ_FREE: begin
              if (cl_q < FIRST_L || cl_q >= lim_q) begin
                res_st <= ST_RANGE;
                state  <= S_RESP;
              end else if (cl_q == FIRST_L) begin
                res_st <= ST_NONE;
                state  <= S_RESP;
              end else begin
                res_st <= ST_OK;
                ptr    <= cl_q - LW'(1);
                state  <= S_CLRD;
              end
            end
            default: begin
              res_st <= ST_RANGE;
              state  <= S_RESP;
            end
          endcase
        end
        S_CLRD: begin
          // Entry of the named cluster is on the read port now.
          if (req_q == REQ_READ) begin
            if (lk.eoc) begin
              res_st <= ST_NONE;
            end else begin
              res_cl <= lk.link;
            end
            state <= S_RESP;
          end else begin
            cl_top      <= mem_rdata[ENTRY_W-1:LINK_W];
            rd_pend     <= 1'b0;
            issued_last <= 1'b0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Check the entry read last cycle while the next read goes out.
          if (hit) begin
            hit_idx <= rd_idx;
            hit_top <= mem_rdata[ENTRY_W-1:LINK_W];
            res_cl  <= LINK_W'(rd_idx);
            state   <= S_WR_HIT;
          end else if (rd_pend && rd_last) begin
            res_st <= ST_NONE;
            state  <= S_RESP;
          end
          rd_pend <= !issued_last;
          if (!issued_last) begin
            rd_idx      <= ptr;
            rd_last     <= is_last;
            issued_last <= is_last;
            ptr         <= ptr_next;
          end
        end
        S_WR_HIT: begin
          state <= (is_alloc && cl_q < FIRST_L) ? S_RESP : S_WR_CL;
        end
        S_WR_CL: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            cluster_out <= res_cl;
            status      <= res_st;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An error result never carries a cluster number.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> cluster_out == '0)
    else $error("error result with nonzero cluster");

  // Scan reads stay inside the data area and below the active limit.
  assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && !issued_last |-> ptr >= FIRST_L && ptr < lim_q)
    else $error("scan pointer out of range");

  // The table is written only in the load and update steps.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_DISPATCH || state == S_WR_HIT || state == S_WR_CL)
    else $error("table write outside an update step");

  // A found entry leads to a table update in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && hit |=> mem_we)
    else $error("found entry not written");

endmodule

/* sim/tb_fat_cluster_chain_manager_top.sv */
// Self-checking testbench for the FAT cluster chain manager top level.
module tb_fat_cluster_chain_manager_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fccm_pkg::*;

  localparam int FAT_N        = FAT_ENTRIES_DEF;
  localparam int FILL_N       = 48;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 3000000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  req_t                 req_type;
  logic [CLUSTER_W-1:0] cluster;
  logic [ENTRY_W-1:0]   entry_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [LINK_W-1:0]    cluster_out;
  status_t              status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_idx_t             cfg_index;
  logic [ENTRY_W-1:0]   cfg_data;

  // One expected result item: the returned cluster and its status.
  typedef struct packed {
    logic [LINK_W-1:0] link;
    status_t           st;
  } chain_reply_t;

  // Shadow copy of the allocation table and the configuration.
  logic [ENTRY_W-1:0] fat_copy [FAT_N];
  bit                 loaded [FAT_N];
  logic               copy_is32;
  logic [USE_W-1:0]   copy_in_use;

  chain_reply_t expected_replies [$];
  chain_reply_t last_reply;
  int           mismatch_cnt;
  int           reply_cnt;
  bit           idle_on;
  bit           in_held;
  int           hold_request;
  int unsigned  cycle_cnt;

  fat_cluster_chain_manager_top #(
    .FAT_ENTRIES(FAT_N)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .cluster(cluster),
    .entry_value(entry_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cluster_out(cluster_out),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Link field of one entry under the current entry size.
  function automatic logic [LINK_W-1:0] link_at(int idx);
    if (copy_is32) return fat_copy[idx][LINK_W-1:0];
    return {{(LINK_W-16){1'b0}}, fat_copy[idx][15:0]};
  endfunction

  function automatic bit at_chain_end(logic [LINK_W-1:0] lk);
    return copy_is32 ? (lk >= EOC32) : (lk >= EOC16);
  endfunction

  // Writes a link; 32-bit entries keep their top bits, 16-bit entries clear the upper half.
  function automatic void store_link(int idx, logic [LINK_W-1:0] lk);
    if (copy_is32) fat_copy[idx] = {fat_copy[idx][ENTRY_W-1:LINK_W], lk};
    else fat_copy[idx] = {16'd0, lk[15:0]};
  endfunction

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic chain_reply_t predict_reply(req_t rq, logic [CLUSTER_W-1:0] cl,
                                                 logic [ENTRY_W-1:0] val);
    chain_reply_t      r;
    int                lim;
    int                c;
    int                i;
    int                hit;
    logic [LINK_W-1:0] lk;
    logic [LINK_W-1:0] eoc;
    r.link = '0;
    r.st   = ST_OK;
    lim    = (copy_in_use < FAT_N) ? int'(copy_in_use) : FAT_N;
    c      = int'(cl);
    eoc    = copy_is32 ? EOC32 : EOC16;
    hit    = -1;
    case (rq)
      REQ_LOAD: begin
        if (c >= FAT_N) begin
          r.st = ST_RANGE;
        end else begin
          fat_copy[c] = val;
          loaded[c]   = 1'b1;
        end
      end
      REQ_READ: begin
        if (c >= FAT_N) begin
          r.st = ST_RANGE;
        end else begin
          lk = link_at(c);
          if (at_chain_end(lk)) r.st = ST_NONE;
          else r.link = lk;
        end
      end
      REQ_ALLOC: begin
        if (c >= lim) begin
          r.st = ST_RANGE;
        end else begin
          // Forward search for a free entry, no wrap.
          for (i = (c < FIRST_DATA) ? FIRST_DATA : c + 1; i < lim && hit < 0; i++)
            if (link_at(i) == '0) hit = i;
          if (hit < 0) begin
            r.st = ST_NONE;
          end else begin
            if (c >= FIRST_DATA) store_link(c, LINK_W'(hit));
            store_link(hit, eoc);
            r.link = LINK_W'(hit);
          end
        end
      end
      REQ_FREE: begin
        if (c < FIRST_DATA || c >= lim) begin
          r.st = ST_RANGE;
        end else begin
          // Backward search for the entry that links to the named cluster.
          for (i = c - 1; i >= FIRST_DATA && hit < 0; i--)
            if (link_at(i) == LINK_W'(c)) hit = i;
          if (hit < 0) begin
            r.st = ST_NONE;
          end else begin
            store_link(hit, eoc);
            store_link(c, '0);
            r.link = LINK_W'(hit);
          end
        end
      end
    endcase
    return r;
  endfunction

  // Random entry word: free, linked into the low area, end of chain, or anything.
  function automatic logic [ENTRY_W-1:0] rand_entry(int span);
    logic [TOP_W-1:0]  top;
    logic [LINK_W-1:0] target;
    top    = TOP_W'($urandom);
    target = LINK_W'($urandom_range(0, span - 1));
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {top, {LINK_W{1'b0}}};
      2: return {top, target};
      3: return {16'($urandom), target[15:0]};
      4: return {top, EOC32 + LINK_W'($urandom_range(0, 7))};
      default: return $urandom;
    endcase
  endfunction

  // Often follows the chain just touched, otherwise a cluster up to the limit or, at times, any value.
  function automatic logic [CLUSTER_W-1:0] pick_cluster(int lim);
    int pick;
    pick = $urandom_range(0, 7);
    if (pick < 4 && last_reply.st == ST_OK && last_reply.link != '0 && last_reply.link < lim)
      return CLUSTER_W'(last_reply.link);
    if (pick == 7) return CLUSTER_W'($urandom);
    return CLUSTER_W'($urandom_range(0, (lim < FAT_N) ? lim : FAT_N - 1));
  endfunction

  // Offers one request item and returns at the edge where it is accepted.
  task automatic send_req(req_t rq, logic [CLUSTER_W-1:0] cl, logic [ENTRY_W-1:0] val);
    chain_reply_t r;
    int           gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      if (in_held) in_valid <= 1'b0;
      in_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rq;
    cluster     <= cl;
    entry_value <= val;
    r = predict_reply(rq, cl, val);
    expected_replies.push_back(r);
    last_reply = r;
    do @(posedge clk); while (!in_ready);
    in_held = 1'b1;
  endtask

  // Lowers valid at the acceptance edge when no item follows right away.
  task automatic drop_input();
    if (in_held) in_valid <= 1'b0;
    in_held = 1'b0;
  endtask

  task automatic wait_drained();
    drop_input();
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // Writes both registers back to back once the block is idle.
  task automatic set_mode(logic is32, int in_use);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FAT_IS_32;
    cfg_data  <= {{(ENTRY_W-1){1'b0}}, is32};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ENTRIES_IN_USE;
    cfg_data  <= ENTRY_W'(in_use);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    copy_is32   = is32;
    copy_in_use = USE_W'(in_use);
  endtask

  // Random requests weighted toward allocate and free along live chains.
  task automatic run_random(int n, int lim);
    int                   k;
    int                   r;
    req_t                 rq;
    logic [CLUSTER_W-1:0] cl;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r < 3) rq = REQ_ALLOC;
      else if (r < 5) rq = REQ_FREE;
      else if (r < 7) rq = REQ_READ;
      else rq = REQ_LOAD;
      cl = pick_cluster(lim);
      // Entries that were never loaded are loaded instead of read.
      if (rq == REQ_READ && !loaded[cl]) rq = REQ_LOAD;
      send_req(rq, cl, rand_entry(lim));
    end
  endtask

  // The low area is loaded once; later scans stay inside it or stop at a loaded entry.
  task automatic test_fill_table();
    int i;
    for (i = 0; i < FILL_N; i++) send_req(REQ_LOAD, CLUSTER_W'(i), rand_entry(64));
  endtask

  // 32-bit entries over the full table: marks, link values and range edges.
  task automatic test_wide_directed();
    logic [CLUSTER_W-1:0] n;
    set_mode(1'b1, 4096);
    send_req(REQ_LOAD, 12'd4095, 32'hFFFF_FFFF);
    send_req(REQ_READ, 12'd4095, 32'h0);
    send_req(REQ_LOAD, 12'd5, 32'hA000_0007);
    send_req(REQ_READ, 12'd5, 32'h0);
    send_req(REQ_LOAD, 12'd6, 32'h0FFF_FFF7);
    send_req(REQ_READ, 12'd6, 32'h0);
    send_req(REQ_LOAD, 12'd7, 32'h5000_0001);
    send_req(REQ_READ, 12'd7, 32'h0);
    send_req(REQ_LOAD, 12'd8, 32'hF000_0000);
    send_req(REQ_READ, 12'd8, 32'h0);
    send_req(REQ_LOAD, 12'd9, 32'h0);
    send_req(REQ_LOAD, 12'd10, 32'h0);
    send_req(REQ_READ, 12'd0, 32'h0);
    send_req(REQ_READ, 12'd1, 32'h0);
    send_req(REQ_ALLOC, 12'd0, 32'h0);
    send_req(REQ_ALLOC, 12'd1, 32'h0);
    send_req(REQ_ALLOC, 12'd5, 32'h0);
    n = CLUSTER_W'(last_reply.link);
    send_req(REQ_READ, 12'd5, 32'h0);
    send_req(REQ_FREE, n, 32'h0);
    send_req(REQ_ALLOC, 12'd4095, 32'h0);
    send_req(REQ_FREE, 12'd0, 32'h0);
    send_req(REQ_FREE, 12'd1, 32'h0);
    // The entry just below the top links to it, so the backward search ends at once.
    send_req(REQ_LOAD, 12'd4094, 32'h3000_0FFF);
    send_req(REQ_FREE, 12'd4095, 32'h0);
  endtask

  // 16-bit entries with the smallest allocation area.
  task automatic test_narrow_directed();
    set_mode(1'b0, 3);
    send_req(REQ_LOAD, 12'd2, 32'h0000_FFF8);
    send_req(REQ_READ, 12'd2, 32'h0);
    send_req(REQ_LOAD, 12'd2, 32'h1234_0000);
    send_req(REQ_READ, 12'd2, 32'h0);
    send_req(REQ_LOAD, 12'd9, 32'hABCD_1234);
    send_req(REQ_READ, 12'd9, 32'h0);
    send_req(REQ_ALLOC, 12'd2, 32'h0);
    send_req(REQ_ALLOC, 12'd3, 32'h0);
    send_req(REQ_ALLOC, 12'd0, 32'h0);
    send_req(REQ_ALLOC, 12'd1, 32'h0);
    send_req(REQ_FREE, 12'd2, 32'h0);
    send_req(REQ_FREE, 12'd3, 32'h0);
    send_req(REQ_READ, 12'd2, 32'h0);
  endtask

  task automatic test_random_wide();
    int lim;
    lim = $urandom_range(16, FILL_N);
    set_mode(1'b1, lim);
    run_random(14, lim);
  endtask

  task automatic test_random_narrow();
    int lim;
    lim = $urandom_range(16, FILL_N);
    set_mode(1'b0, lim);
    run_random(14, lim);
  endtask

  // The receiver holds off while short items keep coming, then the sender waits for all.
  task automatic test_backpressure();
    int k;
    set_mode(1'b1, FILL_N);
    hold_request = LONG_HOLD;
    for (k = 0; k < 12; k++) begin
      if ($urandom_range(0, 1) == 0)
        send_req(REQ_READ, CLUSTER_W'($urandom_range(0, FILL_N - 1)), rand_entry(64));
      else send_req(REQ_LOAD, CLUSTER_W'($urandom_range(0, 63)), rand_entry(64));
    end
    wait_drained();
    run_random(4, FILL_N);
  endtask

  // Loaded area in 16-bit mode with no idling on either side.
  task automatic test_quiet_tail();
    set_mode(1'b0, FILL_N);
    idle_on = 1'b0;
    run_random(10, FILL_N);
  endtask

  // Result receiver: random short stalls and an occasional long hold.
  initial begin : result_sink
    int burst;
    int hold_left;
    burst     = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (burst > 0) begin
        out_ready <= 1'b0;
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        burst = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compares each accepted result item with the oldest expectation.
  initial begin : reply_check
    chain_reply_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) begin
        reply_cnt++;
        if (expected_replies.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d with nothing expected: cluster_out=%0h status=%0d",
                     reply_cnt, cluster_out, status);
        end else begin
          want = expected_replies.pop_front();
          if (cluster_out !== want.link || status !== want.st) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"result %0d: expected cluster_out=%0h status=%0d, ",
                        "got cluster_out=%0h status=%0d"},
                       reply_cnt, want.link, want.st, cluster_out, status);
          end
        end
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_fat_cluster_chain_manager_top: FAIL");
    $finish;
  end

  // Reset, then the tests in turn, then the final verdict.
  initial begin : main_seq
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    req_type    <= REQ_LOAD;
    cluster     <= '0;
    entry_value <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_FAT_IS_32;
    cfg_data    <= '0;
    copy_is32    = FAT_IS_32_RST;
    copy_in_use  = ENTRIES_IN_USE_RST;
    idle_on      = 1'b1;
    in_held      = 1'b0;
    hold_request = 0;
    last_reply   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_fill_table();
    test_wide_directed();
    test_narrow_directed();
    test_random_wide();
    test_random_narrow();
    test_backpressure();
    test_quiet_tail();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_replies.size() == 0) begin
      $display("tb_fat_cluster_chain_manager_top: PASS");
    end else begin
      $display("tb_fat_cluster_chain_manager_top: FAIL");
    end
    $finish;
  end

endmodule

/* fat_cluster_chain_manager_top.f */
rtl/core/fccm_pkg.sv
rtl/core/fccm_table.sv
rtl/core/fccm_link_unit.sv
rtl/core/fat_cluster_chain_manager_top.sv
sim/tb_fat_cluster_chain_manager_top.sv
